### sv/tpc_pkg.sv
// Shared constants and codes for the trie prefix counter.
package tpc_pkg;

	localparam int LETTER_W    = 5;
	localparam int OUT_COUNT_W = 16;

	localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = {OUT_COUNT_W{1'b1}};

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

endpackage

### sv/tpc_ifs.sv
// Valid/ready channel interfaces for letter items and result items.
interface tpc_item_if;
	import tpc_pkg::*;

	logic                valid;
	logic                ready;
	logic                req_type;
	logic [LETTER_W-1:0] letter;
	logic                last;

	modport source (output valid, req_type, letter, last, input ready);
	modport sink   (input valid, req_type, letter, last, output ready);
endinterface

interface tpc_result_if;
	import tpc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [OUT_COUNT_W-1:0] prefix_count;
	logic                   pool_full;

	modport source (output valid, prefix_count, pool_full, input ready);
	modport sink   (input valid, prefix_count, pool_full, output ready);
endinterface

### sv/trie_prefix_counter.sv
// Trie prefix counter top level: word insert and prefix count over a node pool.
//
// Input channel req carries one letter per item (req_type, letter, last).
// Insert letters walk from the root, allocating nodes and bumping pass counts;
// query letters follow existing children. Each item with last set yields one
// result item on rsp: prefix_count for a query, pool_full for an insert.
// Items without last yield nothing.
// Each node is one row of a single-port memory: pass count plus all child
// links. The port serves one access at a time: an item reads its row, an
// insert then writes the update, plus the new node's row when one is allocated;
// a final item reaching an existing node then reads (and, for an insert, bumps)
// its count, and every final item hands its result to the output register.
// The output register lets the next item be taken while a result waits;
// a new result waits in the block until rsp.ready frees the register, and
// no item is accepted meanwhile.
// Reset clears control state and then zeroes the root row in state S_CLR;
// rows of new nodes are cleared on allocation, count 1 for a last letter.
module trie_prefix_counter #(
	parameter int NODE_COUNT    = 4096,
	parameter int ALPHABET_SIZE = 26,
	parameter int COUNT_BITS    = 16
) (
	input logic         clk,
	input logic         arst_n,
	tpc_item_if.sink    req,
	tpc_result_if.source rsp
);
	import tpc_pkg::*;

	localparam int NODE_BITS = $clog2(NODE_COUNT);
	localparam int LTR_W     = $clog2(ALPHABET_SIZE);
	localparam int ROW_W     = COUNT_BITS + ALPHABET_SIZE * NODE_BITS;

	typedef logic [NODE_BITS-1:0]  node_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		count_t                         count;
		logic [ALPHABET_SIZE-1:0][NODE_BITS-1:0] child;
	} row_t;

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_EXEC, S_INIT, S_BRD, S_BWR, S_QCNT, S_RES
	} state_t;

	state_t              state_q;
	node_t               cur_q;
	logic [NODE_BITS:0]  next_free_q;
	logic                missed_q;
	logic                ovf_q;
	logic                type_q;
	logic [LETTER_W-1:0] letter_q;
	logic                last_q;
	logic [OUT_COUNT_W-1:0] res_count_q;
	logic                out_valid_q;
	logic [OUT_COUNT_W-1:0] out_count_q;
	logic                out_full_q;

	logic          ram_we;
	node_t         ram_addr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;

	row_t          row;
	row_t          row_upd;
	row_t          row_new;
	logic [8:0]    letter_ext;
	logic [LTR_W-1:0] letter_idx;
	logic          in_range;
	node_t         child_sel;
	logic          q_hit;
	logic          need_alloc;
	logic          pool_out;
	logic          walk_ok;
	logic          do_walk;
	node_t         target;
	count_t        cnt_bumped;
	logic [32:0]   cnt_ext;
	logic [OUT_COUNT_W-1:0] cnt_sat;
	logic          out_free;

	tpc_node_ram #(
		.DEPTH (NODE_COUNT),
		.WIDTH (ROW_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		row        = row_t'(ram_rdata);
		letter_ext = {{(9 - LETTER_W){1'b0}}, letter_q};
		letter_idx = letter_ext[LTR_W-1:0];
		in_range   = letter_ext < 9'(ALPHABET_SIZE);
		child_sel  = row.child[letter_idx];
		q_hit      = !missed_q && in_range && (child_sel != '0);
		need_alloc = (child_sel == '0);
		pool_out   = next_free_q >= (NODE_BITS + 1)'(NODE_COUNT);
		walk_ok    = !ovf_q && in_range;
		do_walk    = walk_ok && !(need_alloc && pool_out);
		target     = need_alloc ? next_free_q[NODE_BITS-1:0] : child_sel;
		cnt_bumped = (row.count == {COUNT_BITS{1'b1}}) ? row.count : row.count + 1'b1;
		cnt_ext    = 33'(row.count);
		cnt_sat    = (cnt_ext > 33'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX : cnt_ext[OUT_COUNT_W-1:0];
		out_free   = !out_valid_q || rsp.ready;

		row_upd                   = row;
		row_upd.count             = cnt_bumped;
		if (state_q == S_EXEC && do_walk) begin
			row_upd.child[letter_idx] = target;
		end

		row_new       = '0;
		row_new.count = count_t'(last_q);

		ram_we    = 1'b0;
		ram_addr  = cur_q;
		ram_wdata = ROW_W'(row_upd);
		unique case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_addr  = '0;
				ram_wdata = '0;
			end
			S_EXEC: begin
				if (type_q == REQ_QUERY) begin
					ram_addr = child_sel;
				end else begin
					ram_we = do_walk;
				end
			end
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = ROW_W'(row_new);
			end
			S_BWR: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.prefix_count = out_count_q;
	assign rsp.pool_full    = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cur_q       <= '0;
			next_free_q <= (NODE_BITS + 1)'(1);
			missed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			type_q      <= REQ_INSERT;
			letter_q    <= '0;
			last_q      <= 1'b0;
			res_count_q <= '0;
			out_valid_q <= 1'b0;
			out_count_q <= '0;
			out_full_q  <= 1'b0;
		end else begin
			if (state_q == S_RES && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						type_q   <= req.req_type;
						letter_q <= req.letter;
						last_q   <= req.last;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (type_q == REQ_QUERY) begin
						if (q_hit) begin
							cur_q <= child_sel;
						end else begin
							missed_q <= 1'b1;
						end
						res_count_q <= '0;
						if (!last_q) begin
							state_q <= S_IDLE;
						end else if (q_hit) begin
							state_q <= S_QCNT;
						end else begin
							state_q <= S_RES;
						end
					end else if (do_walk) begin
						cur_q <= target;
						if (need_alloc) begin
							next_free_q <= next_free_q + 1'b1;
							state_q     <= S_INIT;
						end else if (last_q) begin
							state_q <= S_BRD;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						if (walk_ok) begin
							ovf_q <= 1'b1;
						end
						state_q <= last_q ? S_RES : S_IDLE;
					end
				end
				S_INIT: begin
					state_q <= last_q ? S_RES : S_IDLE;
				end
				S_BRD: begin
					state_q <= S_BWR;
				end
				S_BWR: begin
					state_q <= S_RES;
				end
				S_QCNT: begin
					res_count_q <= cnt_sat;
					state_q     <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						out_count_q <= (type_q == REQ_QUERY) ? res_count_q : '0;
						out_full_q  <= (type_q == REQ_INSERT) && ovf_q;
						cur_q       <= '0;
						missed_q    <= 1'b0;
						ovf_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/tpc_node_ram.sv
// Single-port node memory with registered read data.
module tpc_node_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 328
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### sv/tpc_checker.sv
// Port-level assertions for the trie prefix counter, bound to the top level.
module tpc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [tpc_pkg::OUT_COUNT_W-1:0] prefix_count,
	input logic                            pool_full
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prefix_count) && $stable(pool_full))
		else $error("result item changed while stalled");

	a_full_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pool_full |-> prefix_count == '0)
		else $error("pool_full result carries a count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted in back-to-back cycles");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result loaded while idle");

endmodule

bind trie_prefix_counter tpc_checker u_tpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.prefix_count (rsp.prefix_count),
	.pool_full    (rsp.pool_full)
);
